// ===== design/tbl_pkg.sv =====
// shared types, codes and constants for the token bucket limiter
// no dependencies; imported by every module of the block
package tbl_pkg;

    typedef enum logic [1:0] {
        CMD_ACQUIRE      = 2'd0,
        CMD_RATE_LIMITED = 2'd1,
        CMD_SUCCESS      = 2'd2,
        CMD_RESERVED     = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [3:0]  ep;
        logic [47:0] now;
    } t_req;

    typedef struct packed {
        logic [37:0] tokens;
        logic [47:0] last;
        logic [47:0] thr;
        logic [4:0]  streak;
    } t_entry;

    localparam logic [37:0] ONE_TOKEN       = 38'd1000000;
    localparam logic [16:0] THR_WAIT_MAX    = 17'd100000;
    localparam logic [16:0] TOK_WAIT_MIN    = 17'd100;
    localparam logic [16:0] TOK_WAIT_MAX    = 17'd100000;
    localparam logic [14:0] BACKOFF_BASE_MS = 15'd500;
    localparam logic [14:0] BACKOFF_MAX_MS  = 15'd30000;
    localparam logic [9:0]  US_PER_MS       = 10'd1000;
    localparam logic [4:0]  STREAK_MAX      = 5'd31;
    localparam logic [47:0] TIME_MAX        = 48'hFFFF_FFFF_FFFF;

    // backoff for a streak already incremented (at least one)
    function automatic logic [14:0] backoff_for_streak(input logic [4:0] streak);
        logic [4:0] shift;
        shift = (streak == 5'd0) ? 5'd0 : streak - 5'd1;
        if (shift > 5'd5) begin
            backoff_for_streak = BACKOFF_MAX_MS;
        end else begin
            backoff_for_streak = BACKOFF_BASE_MS << shift;
        end
    endfunction

endpackage

// ===== design/tbl_front.sv =====
// front end: takes requests, wraps the endpoint index, hands them to the queue
// depends on tbl_pkg
module tbl_front
    import tbl_pkg::*;
#(
    parameter int NUM_ENDPOINTS = 16
) (
    input  logic        i_valid,
    input  logic [1:0]  i_cmd,
    input  logic [3:0]  i_endpoint,
    input  logic [47:0] i_now_us,
    output logic        o_stall,
    input  logic        i_q_full,
    output logic        o_push,
    output t_req        o_req
);

    logic [3:0] w_ep;

    // endpoint modulo the table size, one independent range check per multiple
    always_comb begin
        int base;
        w_ep = i_endpoint;
        for (int k = 0; k < 16; k++) begin
            base = k * NUM_ENDPOINTS;
            if (int'(i_endpoint) >= base && int'(i_endpoint) < base + NUM_ENDPOINTS) begin
                w_ep = 4'(int'(i_endpoint) - base);
            end
        end
    end

    assign o_stall   = i_q_full;
    assign o_push    = i_valid && !i_q_full;
    assign o_req.cmd = t_cmd'(i_cmd);
    assign o_req.ep  = w_ep;
    assign o_req.now = i_now_us;

endmodule

// ===== design/tbl_queue.sv =====
// two-entry request queue between front and back
// depends on tbl_pkg
module tbl_queue
    import tbl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_req,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_req o_req
);

    t_req       r_buf [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_req;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_buf[r_rd];

endmodule

// ===== design/tbl_back.sv =====
// back end: bucket table, refill and spend, backoff, wait divider, result register
// depends on tbl_pkg
module tbl_back
    import tbl_pkg::*;
#(
    parameter int NUM_ENDPOINTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_rate,
    input  logic        i_req_valid,
    input  t_req        i_req,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_granted,
    output logic [16:0] o_wait_us,
    output logic [14:0] o_backoff_ms
);

    localparam int DEPTH = (NUM_ENDPOINTS < 16) ? NUM_ENDPOINTS : 16;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_A    = 7'b0000010,
        S_B    = 7'b0000100,
        S_C    = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_WB   = 7'b0100000,
        S_HOLD = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    t_entry r_mem [DEPTH];
    logic   r_vld [DEPTH];
    t_entry r_rd;
    logic   r_rd_vld;

    t_cmd        r_cmd;
    logic [3:0]  r_ep;
    logic [47:0] r_now;
    logic [37:0] r_first;
    logic [37:0] r_cap;

    t_entry      r_ent;
    logic        r_throttled;
    logic [16:0] r_thr_wait;
    logic        r_adv;
    logic [37:0] r_elapsed;
    logic [4:0]  r_streak_n;
    logic [14:0] r_backoff;
    logic [24:0] r_backoff_us;
    logic [53:0] r_gain;
    logic [47:0] r_until;

    logic        r_grant;
    logic [16:0] r_wait;
    logic        r_use_div;
    logic [15:0] r_rem;
    logic [19:0] r_quo;
    logic [4:0]  r_cnt;

    logic        r_out_valid;
    logic        r_out_granted;
    logic [16:0] r_out_wait;
    logic [14:0] r_out_backoff;

    // stage a: entry after first touch, throttle check, elapsed time, backoff
    t_entry      w_ent;
    logic [47:0] w_thr_diff;
    logic [47:0] w_el;
    always_comb begin
        if (r_rd_vld) begin
            w_ent = r_rd;
        end else begin
            w_ent.tokens = r_first;
            w_ent.last   = r_now;
            w_ent.thr    = '0;
            w_ent.streak = '0;
        end
        w_thr_diff = w_ent.thr - r_now;
        w_el       = r_now - w_ent.last;
    end

    logic [4:0] w_streak_n;
    assign w_streak_n = (w_ent.streak == STREAK_MAX) ? STREAK_MAX : w_ent.streak + 5'd1;

    // stage c: refill saturation and spend
    logic [54:0] w_sum;
    logic [37:0] w_tok;
    assign w_sum = 55'(r_ent.tokens) + 55'(r_gain);
    always_comb begin
        if (!r_adv) begin
            w_tok = r_ent.tokens;
        end else if (w_sum > 55'(r_cap)) begin
            w_tok = r_cap;
        end else begin
            w_tok = w_sum[37:0];
        end
    end

    // one quotient bit per cycle
    logic [16:0] w_rem_sh;
    assign w_rem_sh = {r_rem, r_quo[19]};

    // clamped wait from the quotient
    logic [20:0] w_qp1;
    logic [16:0] w_div_wait;
    assign w_qp1 = 21'(r_quo) + 21'd1;
    always_comb begin
        if (w_qp1 < 21'(TOK_WAIT_MIN)) begin
            w_div_wait = TOK_WAIT_MIN;
        end else if (w_qp1 > 21'(TOK_WAIT_MAX)) begin
            w_div_wait = TOK_WAIT_MAX;
        end else begin
            w_div_wait = w_qp1[16:0];
        end
    end

    logic w_out_free;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_req_valid) n_state = S_A;
            S_A:    n_state = S_B;
            S_B:    n_state = S_C;
            S_C: begin
                if (r_cmd == CMD_ACQUIRE && !r_throttled && i_rate != 16'd0
                    && w_tok < ONE_TOKEN) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_WB;
                end
            end
            S_DIV:  if (r_cnt == 5'd19) n_state = S_WB;
            S_WB:   if (w_out_free) n_state = S_HOLD;
            S_HOLD: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < DEPTH; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_WB && w_out_free) begin
                r_out_valid <= 1'b1;
                if (r_cmd != CMD_RESERVED) begin
                    r_vld[r_ep[IW-1:0]] <= 1'b1;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // table memory, registered read
    always_ff @(posedge i_clk) begin
        if (r_state == S_WB && w_out_free && r_cmd != CMD_RESERVED) begin
            r_mem[r_ep[IW-1:0]] <= r_ent;
        end
        if (r_state == S_IDLE) begin
            r_rd     <= r_mem[i_req.ep[IW-1:0]];
            r_rd_vld <= r_vld[i_req.ep[IW-1:0]];
        end
    end

    // rate-derived constants
    always_ff @(posedge i_clk) begin
        r_first <= 38'((i_rate == 16'd0) ? 16'd1 : i_rate) * ONE_TOKEN;
        r_cap   <= 38'((i_rate == 16'd0) ? 17'd1 : {i_rate, 1'b0}) * ONE_TOKEN;
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cmd <= i_req.cmd;
                r_ep  <= i_req.ep;
                r_now <= i_req.now;
            end
            S_A: begin
                r_ent       <= w_ent;
                r_throttled <= (w_ent.thr != 48'd0) && (r_now < w_ent.thr);
                r_thr_wait  <= (w_thr_diff > 48'(THR_WAIT_MAX)) ? THR_WAIT_MAX
                                                                : w_thr_diff[16:0];
                r_adv       <= r_now > w_ent.last;
                r_elapsed   <= (w_el > 48'(r_cap)) ? r_cap : w_el[37:0];
                r_streak_n  <= w_streak_n;
                r_backoff   <= backoff_for_streak(w_streak_n);
                r_backoff_us <= 25'(backoff_for_streak(w_streak_n)) * 25'(US_PER_MS);
            end
            S_B: begin
                r_gain <= 54'(i_rate) * 54'(r_elapsed);
                if (49'(r_now) + 49'(r_backoff_us) > 49'(TIME_MAX)) begin
                    r_until <= TIME_MAX;
                end else begin
                    r_until <= r_now + 48'(r_backoff_us);
                end
            end
            S_C: begin
                r_grant   <= 1'b0;
                r_wait    <= '0;
                r_use_div <= 1'b0;
                r_rem     <= '0;
                r_cnt     <= '0;
                unique case (r_cmd)
                    CMD_ACQUIRE: begin
                        if (r_throttled) begin
                            r_wait <= r_thr_wait;
                        end else begin
                            r_ent.thr <= '0;
                            if (i_rate == 16'd0) begin
                                r_grant <= 1'b1;
                            end else begin
                                if (r_adv) begin
                                    r_ent.last <= r_now;
                                end
                                if (w_tok >= ONE_TOKEN) begin
                                    r_ent.tokens <= w_tok - ONE_TOKEN;
                                    r_grant      <= 1'b1;
                                end else begin
                                    r_ent.tokens <= w_tok;
                                    r_quo        <= 20'(ONE_TOKEN - w_tok);
                                    r_use_div    <= 1'b1;
                                end
                            end
                        end
                    end
                    CMD_RATE_LIMITED: begin
                        r_ent.streak <= r_streak_n;
                        r_ent.thr    <= r_until;
                    end
                    CMD_SUCCESS: begin
                        if (r_ent.streak != 5'd0) begin
                            r_ent.streak <= '0;
                            r_ent.thr    <= '0;
                        end
                    end
                    default: ;
                endcase
            end
            S_DIV: begin
                r_cnt <= r_cnt + 5'd1;
                if (w_rem_sh >= {1'b0, i_rate}) begin
                    r_rem <= 16'(w_rem_sh - {1'b0, i_rate});
                    r_quo <= {r_quo[18:0], 1'b1};
                end else begin
                    r_rem <= w_rem_sh[15:0];
                    r_quo <= {r_quo[18:0], 1'b0};
                end
            end
            S_WB: begin
                if (w_out_free) begin
                    r_out_granted <= r_grant;
                    r_out_wait    <= r_use_div ? w_div_wait : r_wait;
                    r_out_backoff <= (r_cmd == CMD_RATE_LIMITED) ? r_backoff : '0;
                end
            end
            default: ;
        endcase
    end

    assign o_pop        = (r_state == S_HOLD);
    assign o_out_valid  = r_out_valid;
    assign o_granted    = r_out_granted;
    assign o_wait_us    = r_out_wait;
    assign o_backoff_ms = r_out_backoff;

    a_grant_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_granted |-> o_wait_us == 17'd0 && o_backoff_ms == 15'd0)
        else $error("grant carries a wait or backoff");

    a_wait_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_wait_us <= TOK_WAIT_MAX && o_backoff_ms <= BACKOFF_MAX_MS)
        else $error("wait or backoff out of range");

    a_backoff_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_backoff_ms != 15'd0 |-> o_wait_us == 17'd0 && !o_granted)
        else $error("backoff mixed with acquire result");

    a_pop_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> $past(r_state == S_WB) && o_out_valid)
        else $error("request dropped without a result");

endmodule

// ===== design/token_bucket_limiter_with_backoff.sv =====
// top level of the per-endpoint token bucket limiter with backoff
// depends on tbl_pkg, tbl_front, tbl_queue, tbl_back
//
// request channel: i_in_valid with cmd, endpoint and now_us; o_in_stall
//   holds the sender off while the two-entry queue is full
// result channel: o_out_valid with granted, wait_us and backoff_ms; the
//   receiver raises i_out_stall to hold the result register
// one result per request, in request order
// a request at the queue head passes through the back end in order: table
//   read, touch and throttle check, refill multiply, spend, result write,
//   dequeue; a denied acquire that needs a wait estimate also runs the
//   bit-serial divider in the back end between spend and result write
// the back end takes a new request only after it has dequeued the last one;
//   the sequencer in the back end and its single table port set this
// a stalled result holds the back end in its write-back step, while the
//   front keeps filling the queue until it is full
// reset clears the rate register to zero, empties the queue and marks every
//   bucket as untouched; no clearing pass is needed
// the rate register sits at byte address 0 of the apb port; the user must write
//   it only while no request is in flight, the block itself does not enforce this
module token_bucket_limiter_with_backoff
    import tbl_pkg::*;
#(
    parameter int NUM_ENDPOINTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [3:0]  i_endpoint,
    input  logic [47:0] i_now_us,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_granted,
    output logic [16:0] o_wait_us,
    output logic [14:0] o_backoff_ms,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] ADDR_RATE_QPS = 3'd0;

    logic [15:0] r_rate_qps;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_qps <= '0;
        end else if (psel && penable && pwrite && paddr == ADDR_RATE_QPS) begin
            r_rate_qps <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_RATE_QPS) ? {16'd0, r_rate_qps} : 32'd0;

    // front to queue
    logic q_full;
    logic q_push;
    t_req f_req;

    // queue to back
    logic q_valid;
    logic q_pop;
    t_req q_req;

    tbl_front #(
        .NUM_ENDPOINTS(NUM_ENDPOINTS)
    ) u_front (
        .i_valid    (i_in_valid),
        .i_cmd      (i_cmd),
        .i_endpoint (i_endpoint),
        .i_now_us   (i_now_us),
        .o_stall    (o_in_stall),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_req      (f_req)
    );

    tbl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_req   (f_req),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_req   (q_req)
    );

    tbl_back #(
        .NUM_ENDPOINTS(NUM_ENDPOINTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rate       (r_rate_qps),
        .i_req_valid  (q_valid),
        .i_req        (q_req),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_granted    (o_granted),
        .o_wait_us    (o_wait_us),
        .o_backoff_ms (o_backoff_ms)
    );

endmodule
